// ===== design/thq_pkg.sv =====
`timescale 1ns / 1ps
package thq_pkg;

  localparam int COARSE_SIDE_DEF = 16;
  localparam int MAX_PATCHES_DEF = 16;
  localparam int PATCH_SIDE      = 65;
  localparam int PATCH_AREA      = PATCH_SIDE * PATCH_SIDE;
  localparam int SPAN_SH         = 6;   // PATCH_SIDE - 1 samples per cell edge
  localparam int FINE_SH         = 4;   // fine cells per coarse cell, as a shift
  localparam int WIN_SH          = 2;   // samples per fine cell, as a shift
  localparam int WIN_CTR         = 2;   // centre offset of the window
  localparam int WIN_ROWS        = 6;
  localparam int WIN_COLS        = 5;

  localparam int IDX_W     = 17;
  localparam int VAL_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int PIU_W     = 5;
  localparam int Q_W       = 40;       // magnitude of a scaled index
  localparam int LAT_W     = 7;        // lattice row or column, 0..64

  typedef enum logic [1:0] {
    REQ_GRID_WR   = 2'd0,
    REQ_SAMPLE_WR = 2'd1,
    REQ_HEIGHT    = 2'd2,
    REQ_SEGMENT   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_MISS   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIAS    = 3'd0,
    CFG_CELL    = 3'd1,
    CFG_SAMPLE  = 3'd2,
    CFG_ABSENT  = 3'd3,
    CFG_PATCHES = 3'd4
  } cfg_e;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_SCL_GO,
    SQ_SCL_WAIT,
    SQ_CHECK,
    SQ_GRID,
    SQ_PROBE,
    SQ_WIN,
    SQ_WLAST,
    SQ_FIN
  } seq_e;

  typedef struct packed {
    logic               start;
    logic signed [32:0] sum;
    logic [31:0]        scale;
  } scl_req_t;

  typedef struct packed {
    logic               done;
    logic signed [Q_W:0] value;
  } scl_rsp_t;

endpackage

// ===== design/thq_if.sv =====
`timescale 1ns / 1ps
interface thq_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [16:0]        store_index;
  logic signed [31:0] write_value;
  logic signed [31:0] query_x;
  logic signed [31:0] query_z;
  logic signed [31:0] from_height;
  logic signed [31:0] to_height;

  modport source (output valid, req_type, store_index, write_value, query_x, query_z,
                  from_height, to_height, input ready);
  modport sink (input valid, req_type, store_index, write_value, query_x, query_z,
                from_height, to_height, output ready);
endinterface

interface thq_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] height;
  logic               may_reach;

  modport source (output valid, status, height, may_reach, input ready);
  modport sink (input valid, status, height, may_reach, output ready);
endinterface

// ===== design/thq_scale.sv =====
`timescale 1ns / 1ps
module thq_scale (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  thq_pkg::scl_req_t req_i,
  output thq_pkg::scl_rsp_t rsp_o
);
  import thq_pkg::*;

  logic [32:0]         mag;
  logic [63:0]         prod_d, prod_q;
  logic [31:0]         scale_q;
  logic                hi_q, neg_q, go_q, done_q;
  logic [63:0]         full;
  logic [Q_W-1:0]      q;
  logic signed [Q_W:0] val_d, val_q;

  // magnitude of the biased position; at most 2^32
  assign mag    = req_i.sum[32] ? 33'(-req_i.sum) : 33'(req_i.sum);
  assign prod_d = mag[31:0] * req_i.scale;

  // fold in the top magnitude bit, then truncate toward zero
  assign full  = prod_q + (hi_q ? {scale_q, 32'b0} : 64'b0);
  assign q     = full[63:64-Q_W];
  assign val_d = neg_q ? -$signed({1'b0, q}) : $signed({1'b0, q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      go_q   <= req_i.start;
      done_q <= go_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q  <= prod_d;
      scale_q <= req_i.scale;
      hi_q    <= mag[32];
      neg_q   <= req_i.sum[32];
    end
    if (go_q) begin
      val_q <= val_d;
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = val_q;
endmodule

// ===== design/tiled_heightfield_query.sv =====
`timescale 1ns / 1ps
// Channel    | Dir | Payload
// req_i      | in  | req_type, store_index, write_value, query_x, query_z,
//            |     | from_height, to_height
// rsp_o      | out | status, height, may_reach
// cfg_*_i    | in  | register index, 32-bit write data, write enable
//
// The time an item takes is set by the one shared scaling multiplier, which
// scales one coordinate at a time, and by the single read port of the height
// memory (one window sample a cycle). req_i is ready only in idle; a finished
// item waits in the output register while the next item is taken. Reset clears
// control state and the configuration registers; the stores are undefined until
// written.
module tiled_heightfield_query #(
  parameter int COARSE_SIDE = thq_pkg::COARSE_SIDE_DEF,
  parameter int MAX_PATCHES = thq_pkg::MAX_PATCHES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  thq_req_if.sink                        req_i,
  thq_rsp_if.source                      rsp_o,
  input  logic                           cfg_we_i,
  input  logic [thq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [31:0]                    cfg_wdata_i
);
  import thq_pkg::*;

  localparam int GRID_CELLS = COARSE_SIDE * COARSE_SIDE;
  localparam int GA_W       = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
  localparam int CW         = (COARSE_SIDE > 1) ? $clog2(COARSE_SIDE) : 1;
  localparam int PID_W      = (MAX_PATCHES > 1) ? $clog2(MAX_PATCHES) : 1;
  localparam int DEPTH      = MAX_PATCHES * PATCH_AREA;
  localparam int AW         = $clog2(DEPTH);

  // configuration registers
  logic signed [31:0] bias_q, absent_q;
  logic [31:0]        cell_q, sample_q;
  logic [PIU_W-1:0]   piu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q   <= '0;
      cell_q   <= 32'h0001_0000;
      sample_q <= 32'h0001_0000;
      absent_q <= 32'sh7FFF_FFFF;
      piu_q    <= PIU_W'(16);
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_BIAS:    bias_q   <= cfg_wdata_i;
        CFG_CELL:    cell_q   <= cfg_wdata_i;
        CFG_SAMPLE:  sample_q <= cfg_wdata_i;
        CFG_ABSENT:  absent_q <= cfg_wdata_i;
        CFG_PATCHES: piu_q    <= cfg_wdata_i[PIU_W-1:0];
        default:     ;
      endcase
    end
  end

  // stores
  logic [PID_W-1:0]   grid_mem [GRID_CELLS];
  logic signed [31:0] hs_mem [DEPTH];
  logic               grid_we, grid_re, hs_we, hs_re;
  logic [GA_W-1:0]    grid_waddr, grid_raddr;
  logic [PID_W-1:0]   grid_wdata, grid_rdata_q;
  logic [AW-1:0]      hs_waddr, hs_raddr;
  logic signed [31:0] hs_rdata_q;

  always_ff @(posedge clk_i) begin
    if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
    if (grid_re) grid_rdata_q <= grid_mem[grid_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (hs_we) hs_mem[hs_waddr] <= req_i.write_value;
    if (hs_re) hs_rdata_q <= hs_mem[hs_raddr];
  end

  // sequencer state
  seq_e               st_q, st_d;
  logic [1:0]         k_q, k_d;
  logic               seg_q;
  logic signed [31:0] qx_q, qz_q, from_q, to_q;
  logic signed [Q_W:0] cx_q, cz_q, sx_q, sz_q;
  logic [CW-1:0]      gx_q, gz_q, gx_d, gz_d;
  logic [LAT_W-1:0]   row0_q, col0_q, row0_d, col0_d;
  logic [PID_W-1:0]   patch_q;
  logic [2:0]         wr_q, wr_d, wc_q, wc_d;
  logic               rv_q, rv_d;
  logic signed [32:0] top_q, top_d;
  logic [1:0]         res_status_q, res_status_d;
  logic signed [31:0] res_height_q, res_height_d;
  logic               res_reach_q, res_reach_d;
  logic               out_valid_q, out_load;

  scl_req_t scl_req;
  scl_rsp_t scl_rsp;

  thq_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (scl_req),
    .rsp_o  (scl_rsp)
  );

  logic req_acc;
  assign req_i.ready = (st_q == SQ_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  // scaling job k: bit 0 picks z over x, bit 1 the sample scale over the cell scale
  assign scl_req.start = (st_q == SQ_SCL_GO);
  assign scl_req.sum   = 33'(k_q[0] ? qz_q : qx_q) + 33'(bias_q);
  assign scl_req.scale = k_q[1] ? sample_q : cell_q;

  // write checks
  logic grid_ok, sample_ok;
  assign grid_ok = (32'(req_i.store_index) < 32'(GRID_CELLS)) &&
                   !req_i.write_value[31] &&
                   (req_i.write_value < $signed({27'b0, piu_q})) &&
                   (req_i.write_value < 32'(MAX_PATCHES));
  assign sample_ok = 32'(req_i.store_index) < 32'(DEPTH);

  assign grid_we    = req_acc && (req_e'(req_i.req_type) == REQ_GRID_WR) && grid_ok;
  assign grid_waddr = GA_W'(req_i.store_index);
  assign grid_wdata = PID_W'(req_i.write_value);
  assign hs_we      = req_acc && (req_e'(req_i.req_type) == REQ_SAMPLE_WR) && sample_ok;
  assign hs_waddr   = AW'(req_i.store_index);

  // coarse checks on the fine cells, sample lattice folding
  logic           cx_in, cz_in;
  logic [Q_W-1:0] sgx, sgz;
  logic           sx_last, sz_last, sx_in, sz_in;
  assign cx_in = !cx_q[Q_W] && (cx_q[Q_W-1:FINE_SH] < (Q_W-FINE_SH)'(COARSE_SIDE));
  assign cz_in = !cz_q[Q_W] && (cz_q[Q_W-1:FINE_SH] < (Q_W-FINE_SH)'(COARSE_SIDE));
  assign sgx     = Q_W'(sx_q[Q_W-1:SPAN_SH]);
  assign sgz     = Q_W'(sz_q[Q_W-1:SPAN_SH]);
  assign sx_last = (sgx == Q_W'(COARSE_SIDE));
  assign sz_last = (sgz == Q_W'(COARSE_SIDE));
  assign sx_in   = !sx_q[Q_W] && (sx_last || sgx < Q_W'(COARSE_SIDE));
  assign sz_in   = !sz_q[Q_W] && (sz_last || sgz < Q_W'(COARSE_SIDE));

  // window position
  logic [LAT_W-1:0] wrow, wcol;
  logic             patch_ok, present;
  assign wrow     = row0_q + LAT_W'(wr_q);
  assign wcol     = col0_q + LAT_W'(wc_q);
  assign patch_ok = {{(PID_W+PIU_W){1'b0}}, grid_rdata_q} <
                    {{PID_W{1'b0}}, {(PID_W){1'b0}}, piu_q};
  assign present  = hs_rdata_q < absent_q;

  function automatic logic [AW-1:0] samp_addr(input logic [PID_W-1:0] p,
                                               input logic [LAT_W-1:0] r,
                                               input logic [LAT_W-1:0] c);
    samp_addr = AW'(p) * AW'(PATCH_AREA) + AW'(r) * AW'(PATCH_SIDE) + AW'(c);
  endfunction

  always_comb begin
    st_d         = st_q;
    k_d          = k_q;
    gx_d         = gx_q;
    gz_d         = gz_q;
    row0_d       = row0_q;
    col0_d       = col0_q;
    wr_d         = wr_q;
    wc_d         = wc_q;
    rv_d         = 1'b0;
    top_d        = top_q;
    res_status_d = res_status_q;
    res_height_d = res_height_q;
    res_reach_d  = res_reach_q;
    grid_re      = 1'b0;
    grid_raddr   = GA_W'(gz_q) * GA_W'(COARSE_SIDE) + GA_W'(gx_q);
    hs_re        = 1'b0;
    hs_raddr     = samp_addr(patch_q, wrow, wcol);
    out_load     = 1'b0;
    case (st_q)
      SQ_IDLE: begin
        if (req_acc) begin
          res_status_d = ST_MISS;
          res_height_d = '0;
          res_reach_d  = 1'b0;
          k_d          = 2'd0;
          case (req_e'(req_i.req_type))
            REQ_GRID_WR: begin
              res_status_d = grid_ok ? ST_OK : ST_REJECT;
              st_d         = SQ_FIN;
            end
            REQ_SAMPLE_WR: begin
              res_status_d = sample_ok ? ST_OK : ST_REJECT;
              st_d         = SQ_FIN;
            end
            default: st_d = SQ_SCL_GO;
          endcase
        end
      end
      SQ_SCL_GO: st_d = SQ_SCL_WAIT;
      SQ_SCL_WAIT: begin
        if (scl_rsp.done) begin
          k_d = k_q + 2'd1;
          // a segment only needs the two fine cells
          if ((k_q == 2'd3) || (seg_q && k_q == 2'd1)) st_d = SQ_CHECK;
          else st_d = SQ_SCL_GO;
        end
      end
      SQ_CHECK: begin
        if (!(cx_in && cz_in)) begin
          st_d = SQ_FIN;
        end else if (seg_q) begin
          gx_d   = CW'(cx_q[Q_W-1:FINE_SH]);
          gz_d   = CW'(cz_q[Q_W-1:FINE_SH]);
          col0_d = LAT_W'({cx_q[FINE_SH-1:0], {WIN_SH{1'b0}}});
          row0_d = LAT_W'({cz_q[FINE_SH-1:0], {WIN_SH{1'b0}}});
          st_d   = SQ_GRID;
        end else if (sx_in && sz_in) begin
          // last lattice line folds onto the shared edge of the last patch
          gx_d   = sx_last ? CW'(COARSE_SIDE - 1) : CW'(sgx);
          gz_d   = sz_last ? CW'(COARSE_SIDE - 1) : CW'(sgz);
          col0_d = sx_last ? LAT_W'(PATCH_SIDE - 1) : LAT_W'(sx_q[SPAN_SH-1:0]);
          row0_d = sz_last ? LAT_W'(PATCH_SIDE - 1) : LAT_W'(sz_q[SPAN_SH-1:0]);
          st_d   = SQ_GRID;
        end else begin
          st_d = SQ_FIN;
        end
      end
      SQ_GRID: begin
        // grid read issued here, data lands for the probe step
        grid_re = 1'b1;
        st_d    = SQ_PROBE;
      end
      SQ_PROBE: begin
        if (!patch_ok) begin
          st_d = SQ_FIN;
        end else begin
          hs_re    = 1'b1;
          hs_raddr = seg_q ? samp_addr(grid_rdata_q, row0_q + LAT_W'(WIN_CTR),
                                       col0_q + LAT_W'(WIN_CTR))
                           : samp_addr(grid_rdata_q, row0_q, col0_q);
          wr_d     = '0;
          wc_d     = '0;
          top_d    = -$signed({absent_q[31], absent_q});
          st_d     = SQ_WLAST;
        end
      end
      SQ_WIN: begin
        // issue one window read a cycle unless the row lies past the patch, fold in the sample read last cycle
        hs_re = (wrow < LAT_W'(PATCH_SIDE));
        rv_d  = hs_re;
        if (rv_q && ($signed({hs_rdata_q[31], hs_rdata_q}) > top_q)) begin
          top_d = $signed({hs_rdata_q[31], hs_rdata_q});
        end
        if (wc_q == 3'(WIN_COLS - 1)) begin
          wc_d = '0;
          wr_d = wr_q + 3'd1;
          if (wr_q == 3'(WIN_ROWS - 1)) st_d = SQ_WLAST;
        end else begin
          wc_d = wc_q + 3'd1;
        end
      end
      SQ_WLAST: begin
        if (wr_q == 3'(WIN_ROWS)) begin
          // tail of the window sweep; the last row may have been clipped
          if (rv_q && ($signed({hs_rdata_q[31], hs_rdata_q}) > top_q)) begin
            top_d = $signed({hs_rdata_q[31], hs_rdata_q});
          end
          res_status_d = ST_OK;
          res_reach_d  = !((top_d < $signed({from_q[31], from_q})) &&
                           (top_d < $signed({to_q[31], to_q})));
          st_d = SQ_FIN;
        end else if (!present) begin
          // centre probe or height sample absent
          st_d = SQ_FIN;
        end else if (seg_q) begin
          st_d = SQ_WIN;
        end else begin
          res_status_d = ST_OK;
          res_height_d = hs_rdata_q;
          st_d         = SQ_FIN;
        end
      end
      SQ_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          st_d     = SQ_IDLE;
        end
      end
      default: st_d = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= SQ_IDLE;
      k_q         <= '0;
      wr_q        <= '0;
      wc_q        <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      k_q  <= k_d;
      wr_q <= wr_d;
      wc_q <= wc_d;
      rv_q <= rv_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    gx_q         <= gx_d;
    gz_q         <= gz_d;
    row0_q       <= row0_d;
    col0_q       <= col0_d;
    top_q        <= top_d;
    res_status_q <= res_status_d;
    res_height_q <= res_height_d;
    res_reach_q  <= res_reach_d;
    if (st_q == SQ_PROBE) patch_q <= grid_rdata_q;
    if (req_acc) begin
      seg_q  <= (req_e'(req_i.req_type) == REQ_SEGMENT);
      qx_q   <= req_i.query_x;
      qz_q   <= req_i.query_z;
      from_q <= req_i.from_height;
      to_q   <= req_i.to_height;
    end
    if (scl_rsp.done) begin
      case (k_q)
        2'd0:    cx_q <= scl_rsp.value;
        2'd1:    cz_q <= scl_rsp.value;
        2'd2:    sx_q <= scl_rsp.value;
        default: sz_q <= scl_rsp.value;
      endcase
    end
    if (out_load) begin
      rsp_o.status    <= res_status_q;
      rsp_o.height    <= res_height_q;
      rsp_o.may_reach <= res_reach_q;
    end
  end

  assign rsp_o.valid = out_valid_q;
endmodule

// ===== design/thq_checker.sv =====
`timescale 1ns / 1ps
module thq_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  rsp_status,
  input logic [31:0] rsp_height,
  input logic        rsp_may_reach
);
  import thq_pkg::*;

  logic       req_acc, rsp_acc;
  logic [1:0] open_q;

  assign req_acc = req_valid && req_ready;
  assign rsp_acc = rsp_valid && rsp_ready;

  // items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) open_q <= '0;
    else open_q <= open_q + 2'(req_acc) - 2'(rsp_acc);
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
    $stable(rsp_height) && $stable(rsp_may_reach))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_ready)
    else $error("item taken while busy");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_acc |-> open_q != 2'd0)
    else $error("result without item");

  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_status != ST_OK |-> rsp_height == 32'd0 && !rsp_may_reach)
    else $error("payload on a failed item");
endmodule

bind tiled_heightfield_query thq_assert u_thq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid     (req_i.valid),
  .req_ready     (req_i.ready),
  .rsp_valid     (rsp_o.valid),
  .rsp_ready     (rsp_o.ready),
  .rsp_status    (rsp_o.status),
  .rsp_height    (rsp_o.height),
  .rsp_may_reach (rsp_o.may_reach)
);

// ===== bench/thq_checker.sv =====
`timescale 1ns / 1ps
module thq_checker
  import thq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  thq_req_if                   req_mon,
  thq_rsp_if                   rsp_mon,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  output int                   mismatches_o,
  output int                   answers_due_o
);

  localparam int SIDE        = COARSE_SIDE_DEF;
  localparam int GRID_CELLS  = SIDE * SIDE;
  localparam int STORE_DEPTH = MAX_PATCHES_DEF * PATCH_AREA;
  localparam int SPAN        = PATCH_SIDE - 1;

  typedef struct packed {
    status_e     status;
    logic [31:0] height;
    logic        may_reach;
  } terrain_answer_t;

  longint       bias_q, absent_q;
  logic [31:0]  cell_k, sample_k;
  logic [4:0]   patches_live;

  logic [3:0]          patch_ids [GRID_CELLS];
  logic signed [31:0]  heights [STORE_DEPTH];
  terrain_answer_t     answers_due [$];
  int                  mismatches;

  assign mismatches_o  = mismatches;
  assign answers_due_o = answers_due.size();

  // trunc(s * k / 2^24) on the magnitude, sign put back afterwards
  function automatic longint scaled(longint s, logic [31:0] k);
    logic [32:0] mag;
    logic [64:0] prod;
    mag  = (s < 0) ? 33'(-s) : 33'(s);
    prod = (65'(mag) * 65'(k)) >> 24;
    return (s < 0) ? -longint'(prod[40:0]) : longint'(prod[40:0]);
  endfunction

  function automatic bit cell_inside(longint c);
    return c >= 0 && (c >> FINE_SH) < SIDE;
  endfunction

  function automatic longint sample_at(int patch, int row, int col);
    if (patch >= patches_live || patch >= MAX_PATCHES_DEF || row >= PATCH_SIDE ||
        col >= PATCH_SIDE) begin
      return absent_q;
    end
    return longint'(heights[patch * PATCH_AREA + row * PATCH_SIDE + col]);
  endfunction

  function automatic terrain_answer_t answer_item(req_e kind, int idx, longint wv,
                                                  longint qx, longint qz,
                                                  longint fh, longint th);
    terrain_answer_t a;
    longint cx, cz, sx, sz, h, top, v;
    int gx, gz, rx, rz, patch, fx, fz;
    a = '{status: ST_MISS, height: '0, may_reach: 1'b0};
    case (kind)
      REQ_GRID_WR: begin
        if (idx < GRID_CELLS && wv >= 0 && wv < patches_live && wv < MAX_PATCHES_DEF) begin
          patch_ids[idx] = 4'(wv);
          a.status = ST_OK;
        end else begin
          a.status = ST_REJECT;
        end
      end
      REQ_SAMPLE_WR: begin
        if (idx < STORE_DEPTH) begin
          heights[idx] = 32'(wv);
          a.status = ST_OK;
        end else begin
          a.status = ST_REJECT;
        end
      end
      REQ_HEIGHT: begin
        cx = scaled(qx + bias_q, cell_k);
        cz = scaled(qz + bias_q, cell_k);
        sx = scaled(qx + bias_q, sample_k);
        sz = scaled(qz + bias_q, sample_k);
        if (cell_inside(cx) && cell_inside(cz) && sx >= 0 && sz >= 0 &&
            sx / SPAN <= SIDE && sz / SPAN <= SIDE) begin
          gx = int'(sx / SPAN);
          rx = int'(sx % SPAN);
          gz = int'(sz / SPAN);
          rz = int'(sz % SPAN);
          // last lattice line belongs to the last patch
          if (gx == SIDE) begin
            gx = SIDE - 1;
            rx = SPAN;
          end
          if (gz == SIDE) begin
            gz = SIDE - 1;
            rz = SPAN;
          end
          h = sample_at(patch_ids[gz * SIDE + gx], rz, rx);
          if (h < absent_q) begin
            a.status = ST_OK;
            a.height = 32'(h);
          end
        end
      end
      default: begin
        cx = scaled(qx + bias_q, cell_k);
        cz = scaled(qz + bias_q, cell_k);
        if (cell_inside(cx) && cell_inside(cz)) begin
          patch = patch_ids[int'(cz >> FINE_SH) * SIDE + int'(cx >> FINE_SH)];
          fx = int'(cx & 15);
          fz = int'(cz & 15);
          if (sample_at(patch, fz * 4 + WIN_CTR, fx * 4 + WIN_CTR) < absent_q) begin
            top = -absent_q;
            for (int r = 0; r < WIN_ROWS; r++) begin
              for (int c = 0; c < WIN_COLS; c++) begin
                if (fz * 4 + r < PATCH_SIDE && fx * 4 + c < PATCH_SIDE) begin
                  v = sample_at(patch, fz * 4 + r, fx * 4 + c);
                  if (v > top) top = v;
                end
              end
            end
            a.status    = ST_OK;
            a.may_reach = !(top < fh && top < th);
          end
        end
      end
    endcase
    return a;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  initial mismatches = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    terrain_answer_t want;
    if (!rst_ni) begin
      bias_q       <= 0;
      cell_k       <= 32'd65536;
      sample_k     <= 32'd65536;
      absent_q     <= 64'sd2147483647;
      patches_live <= 5'd16;
    end else begin
      if (cfg_we_i) begin
        case (cfg_e'(cfg_idx_i))
          CFG_BIAS:    bias_q       <= longint'(signed'(cfg_wdata_i));
          CFG_CELL:    cell_k       <= cfg_wdata_i;
          CFG_SAMPLE:  sample_k     <= cfg_wdata_i;
          CFG_ABSENT:  absent_q     <= longint'(signed'(cfg_wdata_i));
          CFG_PATCHES: patches_live <= cfg_wdata_i[4:0];
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready) begin
        answers_due.push_back(answer_item(req_e'(req_mon.req_type),
                                          int'(req_mon.store_index),
                                          longint'(req_mon.write_value),
                                          longint'(req_mon.query_x),
                                          longint'(req_mon.query_z),
                                          longint'(req_mon.from_height),
                                          longint'(req_mon.to_height)));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (answers_due.size() == 0) begin
          report_mismatch("unexpected item", rsp_mon.status, 0);
        end else begin
          want = answers_due.pop_front();
          if (rsp_mon.status != want.status)
            report_mismatch("status", rsp_mon.status, want.status);
          if (rsp_mon.height != want.height)
            report_mismatch("height", rsp_mon.height, want.height);
          if (rsp_mon.may_reach != want.may_reach)
            report_mismatch("may_reach", rsp_mon.may_reach, want.may_reach);
        end
      end
    end
  end

endmodule

// ===== bench/tb_tiled_heightfield_query.sv =====
`timescale 1ns / 1ps
module tb_tiled_heightfield_query;
  import thq_pkg::*;

  localparam int SIDE        = COARSE_SIDE_DEF;
  localparam int GRID_CELLS  = SIDE * SIDE;
  localparam int STORE_DEPTH = MAX_PATCHES_DEF * PATCH_AREA;
  localparam int WATCH_LIMIT = 3000;   // idle cycles; well above the long hold-off
  localparam int SETTLE      = 60;     // beyond the slowest segment query
  localparam int N_PHASES    = 8;
  localparam int PER_PHASE   = 120;
  localparam int HOLD_AT     = 400;    // result count at which the receiver holds off
  localparam int HOLD_LEN    = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  thq_req_if req_ch ();
  thq_rsp_if rsp_ch ();

  int mismatches, answers_due, idle_cycles, results_taken;
  bit calm;
  longint bias_now;
  logic [31:0] cell_now;

  // per phase: world_bias, cell_scale, sample_scale, absent_level, patches_in_use
  // phase 0 runs the directed items; cell_scale just under 1.0 lets the far
  // lattice line be reached while the coarse cell is still inside
  logic [31:0] phase_regs [N_PHASES][5] = '{
    '{32'd0,          32'd65535,      32'd262144,     32'd256000,     32'd16},
    '{32'd0,          32'd65536,      32'd262144,     32'h7FFF_FFFF,  32'd16},
    '{32'h7FFF_FFFF,  32'd65535,      32'd262144,     32'd512000,     32'd9},
    '{32'h8000_0000,  32'd65536,      32'd65536,      32'd0,          32'd16},
    '{32'hFFFF_CE00,  32'd0,          32'd0,          32'h8000_0000,  32'd1},
    '{32'd0,          32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd128000,     32'd16},
    '{32'd76800,      32'd131072,     32'd524288,     32'd384000,     32'd12},
    '{32'd0,          32'd65536,      32'd262144,     32'd640000,     32'd16}
  };

  tiled_heightfield_query i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  thq_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mon       (req_ch),
    .rsp_mon       (rsp_ch),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mismatches_o  (mismatches),
    .answers_due_o (answers_due)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one; none at all while calm.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold the item until taken, then maybe drop valid for a while.
  task automatic send_item(req_e kind, logic [16:0] idx, logic [31:0] wv,
                           logic [31:0] qx, logic [31:0] qz,
                           logic [31:0] fh, logic [31:0] th);
    int g;
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.store_index <= idx;
    req_ch.write_value <= wv;
    req_ch.query_x     <= qx;
    req_ch.query_z     <= qz;
    req_ch.from_height <= fh;
    req_ch.to_height   <= th;
    do @(posedge clk_i); while (!req_ch.ready);
    g = pick_gap();
    if (g > 0) begin
      req_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(cfg_e idx, logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every answer, then let the block fall quiet.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (answers_due != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic enter_phase(int p);
    settle();
    for (int k = 0; k < 5; k++) write_reg(cfg_e'(k), phase_regs[p][k]);
    bias_now = longint'(signed'(phase_regs[p][0]));
    cell_now = phase_regs[p][1];
  endtask

  function automatic logic [31:0] rand_height();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $urandom_range(0, 1536000) - 768000;
  endfunction

  // Aim at the coarse grid under the current scale, with a margin either side.
  function automatic logic [31:0] rand_coord();
    longint span, s;
    if ($urandom_range(0, 9) == 0) return $urandom;
    span = (cell_now == 0) ? 64'd1048576 : (longint'(4200) << 24) / cell_now;
    if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
    if (span < 40) span = 40;
    s = longint'($urandom_range(0, 32'(span))) - span / 40;
    return 32'(s - bias_now);
  endfunction

  function automatic logic [31:0] rand_vertical();
    if ($urandom_range(0, 9) < 3) return $urandom;
    return $urandom_range(0, 2048000) - 1024000;
  endfunction

  task automatic random_item();
    int r;
    logic [16:0] idx;
    logic [31:0] wv;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      idx = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, GRID_CELLS - 1));
      wv  = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 19) - 2;
      send_item(REQ_GRID_WR, idx, wv, $urandom, $urandom, $urandom, $urandom);
    end else if (r < 25) begin
      idx = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, STORE_DEPTH - 1));
      send_item(REQ_SAMPLE_WR, idx, rand_height(), $urandom, $urandom, $urandom, $urandom);
    end else if (r < 62) begin
      send_item(REQ_HEIGHT, 17'($urandom), $urandom, rand_coord(), rand_coord(),
                $urandom, $urandom);
    end else begin
      send_item(REQ_SEGMENT, 17'($urandom), $urandom, rand_coord(), rand_coord(),
                rand_vertical(), rand_vertical());
    end
  endtask

  // Receiver: random stalls, and one long hold-off so the block backs up.
  initial begin
    int hold;
    rsp_ch.ready <= 1'b0;
    results_taken = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
      results_taken++;
      hold = (results_taken == HOLD_AT) ? HOLD_LEN : pick_gap();
      if (hold > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  // Watchdog: too long without any item moving on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    calm = 1'b1;
    bias_now = 0;
    cell_now = 32'd65536;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_BIAS;
    cfg_wdata_i <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_GRID_WR;
    req_ch.store_index <= '0;
    req_ch.write_value <= '0;
    req_ch.query_x     <= '0;
    req_ch.query_z     <= '0;
    req_ch.from_height <= '0;
    req_ch.to_height   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load every grid cell and every sample first, so no query reads an
    // entry that was never written.
    enter_phase(0);
    for (int i = 0; i < GRID_CELLS; i++)
      send_item(REQ_GRID_WR, 17'(i), $urandom_range(0, MAX_PATCHES_DEF - 1), 0, 0, 0, 0);
    for (int i = 0; i < STORE_DEPTH; i++)
      send_item(REQ_SAMPLE_WR, 17'(i), rand_height(), 0, 0, 0, 0);
    calm = 1'b0;

    // Directed: rejected writes, extremes, far lattice line, clipped window.
    send_item(REQ_GRID_WR, 17'(GRID_CELLS), 32'd1, 0, 0, 0, 0);
    send_item(REQ_GRID_WR, 17'd3, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_item(REQ_GRID_WR, 17'd3, 32'd16, 0, 0, 0, 0);
    send_item(REQ_GRID_WR, 17'h1FFFF, 32'h8000_0000, 0, 0, 0, 0);
    send_item(REQ_GRID_WR, 17'(GRID_CELLS - 1), 32'd15, 0, 0, 0, 0);
    send_item(REQ_GRID_WR, 17'd0, 32'd0, 0, 0, 0, 0);
    send_item(REQ_SAMPLE_WR, 17'(STORE_DEPTH), 32'd5, 0, 0, 0, 0);
    send_item(REQ_SAMPLE_WR, 17'h1FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_item(REQ_SAMPLE_WR, 17'd0, 32'h7FFF_FFFF, 0, 0, 0, 0);
    send_item(REQ_SAMPLE_WR, 17'(STORE_DEPTH - 1), 32'h8000_0000, 0, 0, 0, 0);
    send_item(REQ_HEIGHT, 0, 0, 32'd0, 32'd0, 0, 0);
    send_item(REQ_HEIGHT, 0, 0, 32'hFFFF_FF00, 32'd256, 0, 0);
    send_item(REQ_HEIGHT, 0, 0, 32'd65536, 32'd65536, 0, 0);
    send_item(REQ_HEIGHT, 0, 0, 32'd65536, 32'd1280, 0, 0);
    send_item(REQ_HEIGHT, 0, 0, 32'h7FFF_FFFF, 32'd0, 0, 0);
    send_item(REQ_HEIGHT, 0, 0, 32'd0, 32'h8000_0000, 0, 0);
    send_item(REQ_HEIGHT, 0, 0, 32'd65535, 32'd65535, 0, 0);
    send_item(REQ_SEGMENT, 0, 0, 32'd65408, 32'd65408, 32'h8000_0000, 32'h8000_0000);
    send_item(REQ_SEGMENT, 0, 0, 32'd65408, 32'd65408, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(REQ_SEGMENT, 0, 0, 32'd65408, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(REQ_SEGMENT, 0, 0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_item(REQ_SEGMENT, 0, 0, 32'hFFFF_FF00, 32'd0, 32'd0, 32'd0);
    send_item(REQ_SEGMENT, 0, 0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0);

    for (int p = 1; p < N_PHASES; p++) begin
      enter_phase(p);
      repeat (PER_PHASE) random_item();
    end

    settle();
    if (mismatches == 0 && answers_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
